@@ design/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial-division prime tester
// Holds the queue entry type and the widths used by the front, queue and
// divider engine.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the input word and of its magnitude once the sign is split off.
    localparam int VALUE_W = 32;
    localparam int MAG_W   = VALUE_W - 1;

    // Divisors never exceed sqrt(2^31) + 6, so 17 bits hold them with room.
    localparam int DIV_W = 17;
    // The running square of the divisor stays below 2^33.
    localparam int SQ_W  = 34;

    // Bit counter for the restoring remainder loop.
    localparam int CNT_W = $clog2(MAG_W);

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Output word width: prime_flag padded to one byte.
    localparam int OUT_W = 8;

    // Wheel constants.
    localparam int FIRST_DIV   = 3;
    localparam int WHEEL_START = 5;
    localparam int WHEEL_STEP  = 6;
    localparam int PAIR_GAP    = 2;

    // One classified word waiting for the back end.
    typedef struct packed {
        logic             decided;  // verdict already known from the front
        logic             flag;     // verdict when decided is set
        logic [MAG_W-1:0] mag;      // odd magnitude still to be tested
    } job_t;

endpackage

@@ design/trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by 6k +/- 1 trial division
// Top level joining the classifying front, the queue and the divider engine.
// ----------------------------------------------------------------------------
// Usage. Each word on the slave channel carries one signed 32-bit value in
// s_tdata. For each word the master channel returns exactly one word whose
// bit 0 is 1 when the value is prime, in the order the values arrived.
// The front settles negatives, zero, one, two, three and even values at once
// and queues everything, so a word is accepted whenever the queue has room.
// Settled words pass through the queue and the result register when the engine is free.
// An odd value of five or more is first checked against three, then against
// the pairs d and d+2 for d = 5, 11, 17, ... while d*d does not exceed it.
// Each pass runs two restoring remainder units over the 31 magnitude bits:
// one pass is 31 remainder steps plus one bound step, so the run time of a
// value grows with the number of divisor pairs it needs. A large prime
// near 2^31 needs about 7724 pairs.
// The engine works on one value at a time; the queue holds further words.
// Reset (aresetn low at a clock edge) empties the queue, idles the engine and
// drops any pending result. When the receiver holds m_tready low the result
// stays on the master channel and the engine waits with its next result.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int QUEUE_DEPTH = tdpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Slave channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tdpt_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    // Master channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tdpt_pkg::OUT_W-1:0]    m_tdata    // [0] prime_flag, [7:1] zero
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    tdpt_pkg::job_t q_entry;
    tdpt_pkg::job_t q_head;

    // Classification of incoming words.
    tdpt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // Queue between the front and the engine.
    tdpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Trial-division engine with its result register.
    tdpt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ design/tdpt_front.sv @@
// ----------------------------------------------------------------------------
// tdpt_front: input acceptance and quick classification
// Settles negatives, small values and even values at once and hands every
// word to the queue with either its verdict or its magnitude to test.
// ----------------------------------------------------------------------------
module tdpt_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tdpt_pkg::VALUE_W-1:0]    s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output tdpt_pkg::job_t                  q_entry
);

    logic                        neg;
    logic [tdpt_pkg::MAG_W-1:0]  mag;

    assign neg = s_tdata[tdpt_pkg::VALUE_W-1];
    assign mag = s_tdata[tdpt_pkg::MAG_W-1:0];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.mag     = mag;
        q_entry.decided = 1'b1;
        q_entry.flag    = 1'b0;
        if (neg || mag <= tdpt_pkg::MAG_W'(1)) begin
            q_entry.flag = 1'b0;
        end else if (mag <= tdpt_pkg::MAG_W'(3)) begin
            q_entry.flag = 1'b1;
        end else if (!mag[0]) begin
            q_entry.flag = 1'b0;
        end else begin
            // Odd and at least five: the back end decides.
            q_entry.decided = 1'b0;
        end
    end

endmodule

@@ design/tdpt_queue.sv @@
// ----------------------------------------------------------------------------
// tdpt_queue: short first-in first-out queue of classified words
// Decouples the front from the divider engine.
// ----------------------------------------------------------------------------
module tdpt_queue #(
    parameter int DEPTH = tdpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tdpt_pkg::job_t  push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tdpt_pkg::job_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tdpt_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/tdpt_back.sv @@
// ----------------------------------------------------------------------------
// tdpt_back: divider engine and result register
// Runs two restoring remainder units side by side over the wheel divisors
// d and d+2, tracking d squared incrementally as the loop bound.
// ----------------------------------------------------------------------------
module tdpt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  tdpt_pkg::job_t                q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tdpt_pkg::OUT_W-1:0]    m_tdata
);

    localparam int MAG_W = tdpt_pkg::MAG_W;
    localparam int DIV_W = tdpt_pkg::DIV_W;
    localparam int SQ_W  = tdpt_pkg::SQ_W;
    localparam int CNT_W = tdpt_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_NEXT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [MAG_W-1:0] n_reg, n_next;
    logic [DIV_W-1:0] da_reg, da_next;
    logic [DIV_W-1:0] db_reg, db_next;
    logic [DIV_W-1:0] ra_reg, ra_next;
    logic [DIV_W-1:0] rb_reg, rb_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;
    logic             valid_reg, valid_next;
    logic             flag_reg, flag_next;

    logic             out_free;
    logic             bit_in;
    logic [CNT_W-1:0] bit_idx;
    logic [DIV_W:0]   sa, sb;
    logic [DIV_W-1:0] d_step;
    logic [SQ_W-1:0]  sq_step;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(tdpt_pkg::OUT_W-1){1'b0}}, flag_reg};

    // Magnitude bits are fed most significant first.
    assign bit_idx = CNT_W'(MAG_W - 1) - cnt_reg;
    assign bit_in  = n_reg[bit_idx];
    assign sa      = {ra_reg, bit_in};
    assign sb      = {rb_reg, bit_in};

    // Next wheel divisor and its square: (d+6)^2 = d^2 + 12d + 36.
    always_comb begin
        if (first_reg) begin
            d_step  = DIV_W'(tdpt_pkg::WHEEL_START);
            sq_step = SQ_W'(tdpt_pkg::WHEEL_START * tdpt_pkg::WHEEL_START);
        end else begin
            d_step  = da_reg + DIV_W'(tdpt_pkg::WHEEL_STEP);
            sq_step = sq_reg + (SQ_W'(da_reg) << 3) + (SQ_W'(da_reg) << 2)
                      + SQ_W'(tdpt_pkg::WHEEL_STEP * tdpt_pkg::WHEEL_STEP);
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        sq_next    = sq_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        valid_next = valid_reg && !m_tready;
        flag_next  = flag_reg;
        q_pop      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty && out_free) begin
                    q_pop = 1'b1;
                    if (q_head.decided) begin
                        valid_next = 1'b1;
                        flag_next  = q_head.flag;
                    end else begin
                        // Divisibility by three runs first, on both units.
                        n_next     = q_head.mag;
                        da_next    = DIV_W'(tdpt_pkg::FIRST_DIV);
                        db_next    = DIV_W'(tdpt_pkg::FIRST_DIV);
                        ra_next    = '0;
                        rb_next    = '0;
                        cnt_next   = '0;
                        first_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                ra_next  = (sa >= {1'b0, da_reg}) ? DIV_W'(sa - {1'b0, da_reg})
                                                  : DIV_W'(sa);
                rb_next  = (sb >= {1'b0, db_reg}) ? DIV_W'(sb - {1'b0, db_reg})
                                                  : DIV_W'(sb);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (ra_reg == '0 || rb_reg == '0) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        flag_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end else if (sq_step > SQ_W'(n_reg)) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        flag_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    da_next    = d_step;
                    db_next    = d_step + DIV_W'(tdpt_pkg::PAIR_GAP);
                    sq_next    = sq_step;
                    ra_next    = '0;
                    rb_next    = '0;
                    cnt_next   = '0;
                    first_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        sq_reg    <= sq_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        flag_reg  <= flag_next;
    end

endmodule

@@ tb/sv/tb_trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench for the prime tester
// Streams signed 32-bit values into the block and checks that each returned
// word carries the correct prime flag, in order. A short directed pass covers
// the edge values, then random values of several shapes follow. Both sides
// idle at random for most of the run.
// ----------------------------------------------------------------------------

// Tracks the prime flags still owed by the block and checks returned words.
class prime_flag_scoreboard;

    bit owed_flags[$];
    int error_count;

    function new();
        error_count = 0;
    endfunction

    // Trial division by 6k +/- 1, with the divisor square held at 64 bits.
    function bit predict_prime(logic [tdpt_pkg::VALUE_W-1:0] word);
        longint unsigned n;
        longint unsigned d;
        if (word[tdpt_pkg::VALUE_W-1])
            return 1'b0;
        n = word;
        if (n <= 1)
            return 1'b0;
        if (n <= tdpt_pkg::FIRST_DIV)
            return 1'b1;
        if ((n % tdpt_pkg::PAIR_GAP) == 0 || (n % tdpt_pkg::FIRST_DIV) == 0)
            return 1'b0;
        for (d = tdpt_pkg::WHEEL_START; d * d <= n; d += tdpt_pkg::WHEEL_STEP) begin
            if ((n % d) == 0 || (n % (d + tdpt_pkg::PAIR_GAP)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function void note_value(logic [tdpt_pkg::VALUE_W-1:0] word);
        owed_flags.push_back(predict_prime(word));
    endfunction

    function void check_word(logic [tdpt_pkg::OUT_W-1:0] word);
        logic [tdpt_pkg::OUT_W-1:0] wanted;
        if (owed_flags.size() == 0) begin
            $display("%0t: result word %h arrived with no value waiting", $time, word);
            error_count++;
            return;
        end
        wanted = {{(tdpt_pkg::OUT_W-1){1'b0}}, owed_flags.pop_front()};
        if (word !== wanted) begin
            $display("%0t: prime_flag mismatch, expected %h, actual %h",
                     $time, wanted, word);
            error_count++;
        end
    endfunction

    function int pending();
        return owed_flags.size();
    endfunction

endclass

module tb_trial_division_prime_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest single value (2^31 - 1) runs the whole divisor wheel, so the
    // watchdog limit lies well above its run with no word moving on either side.
    localparam int QUIET_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 75;
    localparam int CALM_FROM    = 60;
    localparam int TAIL_CYCLES  = 20;

    // Edge values: the sign boundary, zero, one, the small primes, squares and
    // products of the first wheel divisors, the largest positive values (the
    // top one prime and slow), and a few negatives.
    localparam int CORNER_COUNT = 25;
    localparam logic [31:0] CORNER_VALUES [CORNER_COUNT] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
        32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169,
        32'd999983, 32'd1000003,
        32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555,
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hAAAA_AAAA
    };

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [tdpt_pkg::VALUE_W-1:0] s_tdata  = '0;   // [31:0] value
    logic                         m_tvalid;
    logic                         m_tready = 1'b1;
    logic [tdpt_pkg::OUT_W-1:0]   m_tdata;         // [0] prime_flag, [7:1] zero

    // Idling switches; both are cleared for the final stretch of the run.
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;

    int quiet_cycles = 0;

    prime_flag_scoreboard board = new();

    trial_division_prime_test dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitor both channels at each edge. Values read here are the ones that
    // held just before the edge, so the handshake is seen as the block saw it.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_value(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            board.check_word(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // The receiver drops m_tready for short bursts now and then. After it
    // raises m_tready again it only lowers it at a later edge, so a single
    // edge never sees both a lowering and a raising.
    initial begin
        forever begin
            @(posedge aclk);
            if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Present one word and hold it until the block takes it. A gap, when one
    // is taken, lowers s_tvalid at an edge different from the one raising it.
    task automatic send_value(input logic [tdpt_pkg::VALUE_W-1:0] value);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until every owed flag has come back. The first edge lets the
    // monitor record a word accepted at the current edge.
    task automatic wait_for_drain();
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    // Random values of several shapes. Small and medium ranges are dense in
    // primes and keep the divider loop short; negatives and large multiples
    // of small primes exercise every input bit without a long search; products
    // of two odd numbers reach deep into the wheel before a factor turns up.
    function automatic logic [31:0] draw_value();
        logic [31:0] raw;
        int unsigned pick;
        int unsigned factor;
        int unsigned a;
        int unsigned b;
        raw  = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(0, 2000);
        if (pick < 60)
            return $urandom_range(0, 1 << 20);
        if (pick < 75)
            return {1'b1, raw[30:0]};
        if (pick < 87) begin
            case ($urandom_range(0, 5))
                0: factor = 2;
                1: factor = 3;
                2: factor = 5;
                3: factor = 7;
                4: factor = 11;
                default: factor = 13;
            endcase
            raw[31] = 1'b0;
            return raw - (raw % factor);
        end
        a = 2 * $urandom_range(2, 750) + 1;
        b = 2 * $urandom_range(2, 750) + 1;
        return a * b;
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < CORNER_COUNT; i++)
            send_value(CORNER_VALUES[i]);

        // Hold the sender back until the block has answered everything.
        s_tvalid <= 1'b0;
        wait_for_drain();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == CALM_FROM) begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            send_value(draw_value());
        end
        s_tvalid <= 1'b0;

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a long stretch with no word moving on either side ends the run.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ trial_division_prime_test.f @@
design/tdpt_pkg.sv
design/tdpt_front.sv
design/tdpt_queue.sv
design/tdpt_back.sv
design/trial_division_prime_test.sv
tb/sv/tb_trial_division_prime_test.sv
